// ===== rtl/dcmsc_pkg.sv =====
// Package for the DC motor button speed controller.
// Holds the state and configuration types, codes, reset values and the segment table.
// No dependencies.
package dcmsc_pkg;

    localparam int BTN_W   = 4;
    localparam int SPEED_W = 7;
    localparam int STEP_W  = 5;
    localparam int CNT_W   = 8;
    localparam int PWM_W   = 8;
    localparam int DIG_W   = 2;
    localparam int SEG_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESUME      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_TIME   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 2'd3;

    // Active-low single-button codes
    localparam logic [BTN_W-1:0] BTN_UP   = 4'hE;
    localparam logic [BTN_W-1:0] BTN_DOWN = 4'hD;
    localparam logic [BTN_W-1:0] BTN_REV  = 4'hB;
    localparam logic [BTN_W-1:0] BTN_STOP = 4'h7;

    // Digit select codes and digit scan positions
    localparam logic [DIG_W-1:0] DIG_UNITS = 2'd3;
    localparam logic [DIG_W-1:0] DIG_TENS  = 2'd2;
    localparam logic [DIG_W-1:0] DIG_SIGN  = 2'd1;
    localparam logic [1:0] SCAN_UNITS = 2'd0;
    localparam logic [1:0] SCAN_TENS  = 2'd1;
    localparam logic [1:0] SCAN_SIGN  = 2'd2;

    localparam logic [SPEED_W-1:0] SPEED_MAX   = 7'd100;
    localparam logic [SPEED_W-1:0] SHOW_CLAMP  = 7'd95;
    localparam logic [SPEED_W-1:0] SHOW_MAX    = 7'd99;
    localparam logic [SEG_W-1:0]   SEG_BLANK   = 8'hFF;
    localparam logic [SEG_W-1:0]   SEG_MINUS   = 8'hBF;

    // 255*s/100 == (s * 1336965) >> 19 for s below 128
    localparam int PWM_PROD_W = 28;
    localparam logic [20:0] PWM_RECIP = 21'd1336965;
    localparam int PWM_SHIFT = 19;

    // v/10 == (v * 205) >> 11 for v below 100
    localparam int TENS_PROD_W = 15;
    localparam logic [7:0] TENS_RECIP = 8'd205;
    localparam int TENS_SHIFT = 11;

    typedef struct packed {
        logic [STEP_W-1:0]  speed_step;
        logic [SPEED_W-1:0] resume_speed;
        logic [CNT_W-1:0]   dead_time_ticks;
        logic [SPEED_W-1:0] speed_limit;
    } t_cfg;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [SPEED_W-1:0] saved;
        logic               dir_fwd;
        logic               stopped;
        logic               reversing;
        logic               latched;
        logic [CNT_W-1:0]   dead_cnt;
        logic               dead_done;
        logic [1:0]         digit_idx;
        logic               fwd_off;
        logic               rev_off;
        logic [PWM_W-1:0]   pwm;
        logic [DIG_W-1:0]   dig_en;
        logic [SEG_W-1:0]   seg;
    } t_state;

    localparam t_cfg CFG_RESET = '{
        speed_step:      5'd5,
        resume_speed:    7'd50,
        dead_time_ticks: 8'd100,
        speed_limit:     7'd100
    };

    localparam t_state STATE_RESET = '{
        speed:     7'd50,
        saved:     7'd50,
        dir_fwd:   1'b1,
        stopped:   1'b0,
        reversing: 1'b0,
        latched:   1'b0,
        dead_cnt:  8'd100,
        dead_done: 1'b0,
        digit_idx: SCAN_UNITS,
        fwd_off:   1'b0,
        rev_off:   1'b1,
        pwm:       8'd128,
        dig_en:    DIG_UNITS,
        seg:       SEG_BLANK
    };

    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 8'hC0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'hA4;
            4'd3:    code = 8'hB0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/dcmsc_in_if.sv =====
// Input channel of the DC motor controller: button levels and tick flag.
// Depends on dcmsc_pkg.
interface dcmsc_in_if;
    logic                         valid;
    logic                         ready;
    logic [dcmsc_pkg::BTN_W-1:0]  button_levels;
    logic                         tick;

    modport source (output valid, output button_levels, output tick, input ready);
    modport sink   (input valid, input button_levels, input tick, output ready);
endinterface

// ===== rtl/dcmsc_out_if.sv =====
// Result channel of the DC motor controller: PWM level, bridge legs and display.
// Depends on dcmsc_pkg.
interface dcmsc_out_if;
    logic                         valid;
    logic                         ready;
    logic [dcmsc_pkg::PWM_W-1:0]  pwm_level;
    logic                         leg_forward_off;
    logic                         leg_reverse_off;
    logic [dcmsc_pkg::DIG_W-1:0]  digit_enable;
    logic [dcmsc_pkg::SEG_W-1:0]  segment_pattern;

    modport source (output valid, output pwm_level, output leg_forward_off,
                    output leg_reverse_off, output digit_enable, output segment_pattern,
                    input ready);
    modport sink   (input valid, input pwm_level, input leg_forward_off,
                    input leg_reverse_off, input digit_enable, input segment_pattern,
                    output ready);
endinterface

// ===== rtl/dcmsc_step.sv =====
// Next-state logic of the DC motor controller for one sampled item.
// Dead-time count, button handling, PWM/display refresh and reversal completion.
// Depends on dcmsc_pkg.
module dcmsc_step (
    input  dcmsc_pkg::t_state                i_state,
    input  dcmsc_pkg::t_cfg                  i_cfg,
    input  logic [dcmsc_pkg::BTN_W-1:0]      i_buttons,
    input  logic                             i_tick,
    output dcmsc_pkg::t_state                o_state
);
    import dcmsc_pkg::*;

    logic [SPEED_W-1:0]     lim;
    logic [SPEED_W-1:0]     resume_c;
    logic [SPEED_W:0]       up_sum;
    logic [SPEED_W-1:0]     up_val;
    logic [SPEED_W-1:0]     shown;
    logic [PWM_PROD_W-1:0]  pwm_prod;
    logic [TENS_PROD_W-1:0] tens_prod;
    logic [3:0]             tens;
    logic [SPEED_W-1:0]     units_full;
    logic [3:0]             units;
    t_state                 nx;

    assign lim      = (i_cfg.speed_limit > SPEED_MAX) ? SPEED_MAX : i_cfg.speed_limit;
    assign resume_c = (i_cfg.resume_speed > SPEED_MAX) ? SPEED_MAX : i_cfg.resume_speed;
    assign up_sum   = {1'b0, i_state.speed} + {3'b000, i_cfg.speed_step};
    assign up_val   = (up_sum > {1'b0, lim}) ? lim : up_sum[SPEED_W-1:0];

    always_comb begin
        nx = i_state;

        // Dead-time count runs ahead of the buttons
        if (i_tick) begin
            nx.dead_cnt = i_state.dead_cnt - 8'd1;
            if (nx.dead_cnt == '0) begin
                nx.dead_done = 1'b1;
            end
        end

        // A single pressed button acts once, then waits for release
        case (i_buttons)
            BTN_UP: begin
                nx.latched = 1'b1;
                if (!i_state.latched && (i_state.speed < lim)) begin
                    nx.speed = up_val;
                end
            end
            BTN_DOWN: begin
                nx.latched = 1'b1;
                if (!i_state.latched && (i_state.speed >= {2'b00, i_cfg.speed_step})) begin
                    nx.speed = i_state.speed - {2'b00, i_cfg.speed_step};
                end
            end
            BTN_REV: begin
                nx.latched = 1'b1;
                if (!i_state.latched && !i_state.stopped && !i_state.reversing) begin
                    nx.reversing = 1'b1;
                    nx.dir_fwd   = !i_state.rev_off;
                    nx.fwd_off   = 1'b1;
                    nx.rev_off   = 1'b1;
                    nx.saved     = i_state.speed;
                    nx.speed     = '0;
                    nx.dead_cnt  = i_cfg.dead_time_ticks;
                    nx.dead_done = 1'b0;
                end
            end
            BTN_STOP: begin
                nx.latched = 1'b1;
                if (!i_state.latched) begin
                    nx.stopped = !i_state.stopped;
                    nx.speed   = i_state.stopped ? resume_c : '0;
                end
            end
            default: begin
                nx.latched = 1'b0;
            end
        endcase

        // Refresh values come from the speed after the buttons
        shown      = (nx.speed >= SHOW_CLAMP) ? SHOW_MAX : nx.speed;
        pwm_prod   = PWM_PROD_W'(nx.speed) * PWM_PROD_W'(PWM_RECIP);
        tens_prod  = TENS_PROD_W'(shown) * TENS_PROD_W'(TENS_RECIP);
        tens       = tens_prod[TENS_SHIFT+3:TENS_SHIFT];
        units_full = shown - SPEED_W'({tens, 3'b000} + {2'b00, tens, 1'b0});
        units      = units_full[3:0];

        if (i_tick) begin
            nx.pwm = pwm_prod[PWM_SHIFT+PWM_W-1:PWM_SHIFT];
            case (i_state.digit_idx)
                SCAN_UNITS: begin
                    nx.dig_en    = DIG_UNITS;
                    nx.seg       = seg_code(units);
                    nx.digit_idx = SCAN_TENS;
                end
                SCAN_TENS: begin
                    nx.dig_en    = DIG_TENS;
                    nx.seg       = seg_code(tens);
                    nx.digit_idx = SCAN_SIGN;
                end
                SCAN_SIGN: begin
                    nx.dig_en    = DIG_SIGN;
                    nx.seg       = nx.dir_fwd ? SEG_BLANK : SEG_MINUS;
                    nx.digit_idx = SCAN_UNITS;
                end
                default: begin
                    nx.digit_idx = SCAN_UNITS;
                end
            endcase

            // Finish the reversal: enable the new leg and restore the speed
            if (!nx.stopped && nx.reversing && nx.dead_done) begin
                if (nx.dir_fwd) begin
                    nx.fwd_off = 1'b0;
                end else begin
                    nx.rev_off = 1'b0;
                end
                nx.reversing = 1'b0;
                nx.speed     = nx.saved;
            end
        end
    end

    assign o_state = nx;

endmodule

// ===== rtl/dc_motor_button_speed_controller_unit.sv =====
// Top level of the button-driven DC motor speed and direction controller.
// Depends on dcmsc_pkg, dcmsc_in_if, dcmsc_out_if and dcmsc_step.
//
// Usage:
//   i_in  carries one sample per transfer: four active-low button levels and a
//         5 ms tick flag. o_out carries one result per sample: the PWM compare
//         value, the two bridge leg controls and the current display digit.
//   i_cfg_we/i_cfg_idx/i_cfg_data write the step, resume speed, dead time and
//         speed limit registers; write only while no sample is in flight.
// Timing:
//   A sample lands in the input register, passes through one level of update
//   logic and leaves in the result register together with the controller
//   state; it moves on from the input register only when the result register
//   is empty or its result is being taken.
//   One sample per cycle is taken for as long as the receiver takes results.
// Reset (synchronous, active low): speed 50, forward leg on, reverse leg off,
//   PWM 128, display blank on the units digit, registers at their defaults.
// Stall: while the result waits, one more sample is held in the input
//   register; after that i_in.ready drops until the result is taken.
module dc_motor_button_speed_controller_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    dcmsc_in_if.sink                            i_in,
    dcmsc_out_if.source                         o_out,
    input  logic                                i_cfg_we,
    input  logic [dcmsc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dcmsc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import dcmsc_pkg::*;

    logic              r_in_valid;
    logic [BTN_W-1:0]  r_in_buttons;
    logic              r_in_tick;
    logic              r_out_valid;
    t_state            r_state;
    t_state            n_state;
    t_cfg              r_cfg;
    logic              advance;
    logic              in_xfer;

    assign advance = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_xfer = i_in.valid && i_in.ready;

    dcmsc_step u_step (
        .i_state   (r_state),
        .i_cfg     (r_cfg),
        .i_buttons (r_in_buttons),
        .i_tick    (r_in_tick),
        .o_state   (n_state)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_buttons <= i_in.button_levels;
            r_in_tick    <= i_in.tick;
        end
    end

    // State and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SPEED_STEP:  r_cfg.speed_step      <= i_cfg_data[STEP_W-1:0];
                CFG_RESUME:      r_cfg.resume_speed    <= i_cfg_data[SPEED_W-1:0];
                CFG_DEAD_TIME:   r_cfg.dead_time_ticks <= i_cfg_data[CNT_W-1:0];
                CFG_SPEED_LIMIT: r_cfg.speed_limit     <= i_cfg_data[SPEED_W-1:0];
            endcase
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.pwm_level       = r_state.pwm;
    assign o_out.leg_forward_off = r_state.fwd_off;
    assign o_out.leg_reverse_off = r_state.rev_off;
    assign o_out.digit_enable    = r_state.dig_en;
    assign o_out.segment_pattern = r_state.seg;

`ifndef SYNTHESIS
    a_legs_never_both_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(!r_state.fwd_off && !r_state.rev_off))
        else $error("both bridge legs enabled");

    a_reversal_legs_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.reversing |-> (r_state.fwd_off && r_state.rev_off))
        else $error("bridge leg enabled during dead time");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.digit_idx != 2'd3)
        else $error("digit scan position out of range");

    a_state_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("controller state changed without a sample");
`endif

endmodule
